/* src/chist_pkg.sv */
package chist_pkg;

    localparam int ALPHABET_SIZE = 128;
    localparam int COUNT_BITS    = 16;
    localparam int CODE_BITS     = 8;

    localparam int SYM_BITS  = $clog2(ALPHABET_SIZE);
    localparam int PTR_BITS  = SYM_BITS + 1;
    localparam int LANES     = 8;
    localparam int LANE_BITS = $clog2(LANES);
    localparam int GRP_BITS  = SYM_BITS - LANE_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [GRP_BITS-1:0]   GRP_LAST  = '1;

    typedef struct packed {
        logic                count;
        logic                rd;
        logic                clear;
        logic [SYM_BITS-1:0] addr;
    } t_store_req;

    typedef struct packed {
        logic                done;
        logic                hit;
        logic [SYM_BITS-1:0] pos;
    } t_scan_res;

endpackage

/* src/character_histogram.sv */
// Character histogram.
// Input channel (i_valid/o_ready): each word carries i_command and i_char_code.
// A count word (command 0) adds one to the saturating 16-bit count of its
// character; codes 0 and 128-255 are ignored. Count words are taken one per
// cycle and give no result.
// A report word (command 1) returns, on the output channel (o_valid/i_ready),
// the next nonzero entry at or after the scan pointer in ascending code order,
// with o_found and o_last. When o_last is set, all counts are cleared and the
// pointer returns to code 0.
// The flag scanner examines one group of eight codes per cycle, once to find
// the entry and once to look for a following one from there, so a report
// examines at most 17 groups. The result is loaded into the output register
// in the emit state, and the next word is taken once the block is back in idle.
// No word is taken while a report is in progress.
// Reset clears all counts at once through per-entry nonzero flags.
// A finished result waits in the output register while the receiver stalls;
// count words are still taken, and a report holds until the register frees.
module character_histogram import chist_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [CODE_BITS-1:0]  i_char_code,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SYM_BITS-1:0]   o_symbol,
    output logic [COUNT_BITS-1:0] o_occurrences,
    output logic                  o_found,
    output logic                  o_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIND1 = 2'd1;
    localparam logic [1:0] ST_FIND2 = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [PTR_BITS-1:0]      r_ptr;
    logic [SYM_BITS-1:0]      r_hit;
    logic                     r_found;
    logic                     r_last;
    logic [COUNT_BITS-1:0]    r_occ;
    logic                     r_out_valid;
    logic [SYM_BITS-1:0]      r_out_symbol;
    logic [COUNT_BITS-1:0]    r_out_occ;
    logic                     r_out_found;
    logic                     r_out_last;

    logic                     w_acc;
    logic                     w_code_ok;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_scan_start;
    logic [PTR_BITS-1:0]      w_scan_pos;
    t_store_req               w_req;
    t_scan_res                w_res;
    logic [COUNT_BITS-1:0]    w_rd_data;
    logic [ALPHABET_SIZE-1:0] w_nz;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_code_ok  = (i_char_code != '0)
                        && ({1'b0, i_char_code} < (CODE_BITS + 1)'(ALPHABET_SIZE));
    assign w_out_free = !r_out_valid || i_ready;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;

    always_comb begin
        w_req.count  = w_acc && !i_command && w_code_ok;
        w_req.rd     = (r_state == ST_FIND1) && w_res.done && w_res.hit;
        w_req.clear  = w_emit && r_last;
        w_req.addr   = w_req.count ? i_char_code[SYM_BITS-1:0] : w_res.pos;
        w_scan_start = (w_acc && i_command) || w_req.rd;
        w_scan_pos   = w_req.rd ? ({1'b0, w_res.pos} + 1'b1) : r_ptr;
    end

    chist_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data),
        .o_nz      (w_nz)
    );

    chist_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_scan_start),
        .i_start_pos (w_scan_pos),
        .i_nz        (w_nz),
        .o_res       (w_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_command) begin
                    n_state = ST_FIND1;
                end
            end
            ST_FIND1: begin
                if (w_res.done) begin
                    n_state = w_res.hit ? ST_FIND2 : ST_EMIT;
                end
            end
            ST_FIND2: begin
                if (w_res.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_ptr       <= r_last ? '0 : ({1'b0, r_hit} + 1'b1);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIND1) && w_res.done) begin
            r_hit   <= w_res.hit ? w_res.pos : '0;
            r_found <= w_res.hit;
            r_last  <= !w_res.hit;
            r_occ   <= '0;
        end
        if ((r_state == ST_FIND2) && w_res.done) begin
            r_last <= !w_res.hit;
            r_occ  <= w_rd_data;
        end
        if (w_emit) begin
            r_out_symbol <= r_hit;
            r_out_occ    <= r_occ;
            r_out_found  <= r_found;
            r_out_last   <= r_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_symbol      = r_out_symbol;
    assign o_occurrences = r_out_occ;
    assign o_found       = r_out_found;
    assign o_last        = r_out_last;

endmodule

/* src/chist_store.sv */
module chist_store import chist_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_store_req               i_req,
    output logic [COUNT_BITS-1:0]    o_rd_data,
    output logic [ALPHABET_SIZE-1:0] o_nz
);

    logic [COUNT_BITS-1:0]    r_mem [ALPHABET_SIZE];
    logic [COUNT_BITS-1:0]    r_rd_data;
    logic [ALPHABET_SIZE-1:0] r_nz;
    logic                     r_s2_valid;
    logic [SYM_BITS-1:0]      r_s2_addr;
    logic                     r_fw_valid;
    logic [SYM_BITS-1:0]      r_fw_addr;
    logic [COUNT_BITS-1:0]    r_fw_data;
    logic [COUNT_BITS-1:0]    w_old;
    logic [COUNT_BITS-1:0]    w_new;

    // The write of the previous cycle is not yet visible in the read data.
    always_comb begin
        if (r_fw_valid && (r_fw_addr == r_s2_addr)) begin
            w_old = r_fw_data;
        end else if (r_nz[r_s2_addr]) begin
            w_old = r_rd_data;
        end else begin
            w_old = '0;
        end
        w_new = (w_old == COUNT_MAX) ? w_old : w_old + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_mem[r_s2_addr] <= w_new;
        end
        if (i_req.count || i_req.rd) begin
            r_rd_data <= r_mem[i_req.addr];
        end
        r_s2_addr <= i_req.addr;
        r_fw_addr <= r_s2_addr;
        r_fw_data <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_nz       <= '0;
        end else begin
            r_s2_valid <= i_req.count;
            if (i_req.clear) begin
                r_nz       <= '0;
                r_fw_valid <= 1'b0;
            end else begin
                r_fw_valid <= r_s2_valid;
                if (r_s2_valid) begin
                    r_nz[r_s2_addr] <= 1'b1;
                end
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_nz      = r_nz;

endmodule

/* src/chist_scan.sv */
module chist_scan import chist_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [PTR_BITS-1:0]      i_start_pos,
    input  logic [ALPHABET_SIZE-1:0] i_nz,
    output t_scan_res                o_res
);

    logic                 r_active;
    logic [PTR_BITS-1:0]  r_cur;
    logic [GRP_BITS-1:0]  w_grp;
    logic [LANE_BITS-1:0] w_lo;
    logic [LANES-1:0]     w_window;
    logic                 w_any;
    logic [LANE_BITS-1:0] w_idx;
    logic                 w_hit;
    logic                 w_done;

    // Eight flags are examined per cycle, starting at the cursor.
    always_comb begin
        w_grp    = r_cur[SYM_BITS-1:LANE_BITS];
        w_lo     = r_cur[LANE_BITS-1:0];
        w_window = i_nz[w_grp*LANES +: LANES];
        w_any    = 1'b0;
        w_idx    = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (w_window[i] && (LANE_BITS'(i) >= w_lo)) begin
                w_any = 1'b1;
                w_idx = LANE_BITS'(i);
            end
        end
        w_hit  = w_any && !r_cur[SYM_BITS];
        w_done = r_active && (w_hit || r_cur[SYM_BITS] || (w_grp == GRP_LAST));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (w_done) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur <= i_start_pos;
        end else if (r_active && !w_done) begin
            r_cur <= {1'b0, w_grp + 1'b1, {LANE_BITS{1'b0}}};
        end
    end

    assign o_res.done = w_done;
    assign o_res.hit  = w_hit;
    assign o_res.pos  = {w_grp, w_idx};

endmodule

/* src/chist_checker.sv */
module chist_checker import chist_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [SYM_BITS-1:0]   o_symbol,
    input logic [COUNT_BITS-1:0] o_occurrences,
    input logic                  o_found,
    input logic                  o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_symbol) && $stable(o_occurrences))
        else $error("Output word dropped or changed while stalled.");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last)
        else $error("Empty report does not end the run.");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_symbol == '0) && (o_occurrences == '0))
        else $error("Empty report carries a symbol or count.");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_occurrences != '0) && (o_symbol != '0))
        else $error("Reported entry has a zero count or code.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

endmodule

bind character_histogram chist_checker u_chist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_symbol      (o_symbol),
    .o_occurrences (o_occurrences),
    .o_found       (o_found),
    .o_last        (o_last)
);

/* dv/tb_character_histogram.sv */
`timescale 1ns / 100ps

module tb_character_histogram import chist_pkg::*;;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_SHOWN    = 10;
    localparam int REPEAT_WORDS = 100;
    localparam int HOLDOFF_LEN  = 400;

    typedef struct packed {
        logic [SYM_BITS-1:0]   symbol;
        logic [COUNT_BITS-1:0] occurrences;
        logic                  found;
        logic                  last;
    } t_hist_entry;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_command;
    logic [CODE_BITS-1:0]  i_char_code;
    logic                  o_valid;
    logic                  i_ready;
    logic [SYM_BITS-1:0]   o_symbol;
    logic [COUNT_BITS-1:0] o_occurrences;
    logic                  o_found;
    logic                  o_last;

    logic [COUNT_BITS-1:0] shadow_counts [ALPHABET_SIZE];
    int                    shadow_pointer;
    logic                  run_closed;
    t_hist_entry           expected_entries [$];

    int mismatch_count;
    int words_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int holdoff_requests;
    int holdoff_served;
    int holdoff_left;
    int cycle_count;

    character_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_occurrences (o_occurrences),
        .o_found       (o_found),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver stalls at random, or for a whole stretch when one is requested.
    initial begin
        i_ready        = 1'b0;
        holdoff_served = 0;
        holdoff_left   = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_served != holdoff_requests) begin
                holdoff_served = holdoff_requests;
                holdoff_left   = HOLDOFF_LEN;
            end
            if (holdoff_left > 0) begin
                i_ready = 1'b0;
                holdoff_left--;
            end else begin
                i_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic int next_nonzero(input int from);
        int idx;
        for (idx = from; idx < ALPHABET_SIZE; idx++) begin
            if (shadow_counts[idx] != '0) begin
                return idx;
            end
        end
        return ALPHABET_SIZE;
    endfunction

    task automatic clear_shadow();
        foreach (shadow_counts[idx]) begin
            shadow_counts[idx] = '0;
        end
        shadow_pointer = 0;
    endtask

    // Updates the expected histogram for one accepted word and queues the
    // entry that a report word must return.
    task automatic apply_word(input logic cmd, input logic [CODE_BITS-1:0] code);
        int          hit;
        int          idx;
        t_hist_entry entry;
        idx = int'(code);
        if (cmd == CMD_COUNT) begin
            if (idx != 0 && idx < ALPHABET_SIZE && shadow_counts[idx] != COUNT_MAX) begin
                shadow_counts[idx] = shadow_counts[idx] + 1'b1;
            end
            return;
        end
        hit = next_nonzero(shadow_pointer);
        if (hit >= ALPHABET_SIZE) begin
            entry.symbol      = '0;
            entry.occurrences = '0;
            entry.found       = 1'b0;
            entry.last        = 1'b1;
        end else begin
            entry.symbol      = hit[SYM_BITS-1:0];
            entry.occurrences = shadow_counts[hit];
            entry.found       = 1'b1;
            entry.last        = (next_nonzero(hit + 1) >= ALPHABET_SIZE);
        end
        if (entry.last) begin
            clear_shadow();
        end else begin
            shadow_pointer = hit + 1;
        end
        run_closed = entry.last;
        expected_entries.push_back(entry);
    endtask

    always @(posedge i_clk) begin
        t_hist_entry want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("unexpected entry: symbol %0d occurrences %0d found %0b last %0b",
                             o_symbol, o_occurrences, o_found, o_last);
                end
            end else begin
                want = expected_entries.pop_front();
                if (o_symbol !== want.symbol || o_occurrences !== want.occurrences ||
                    o_found !== want.found || o_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("entry mismatch: symbol %0d/%0d occurrences %0d/%0d %s",
                                 want.symbol, o_symbol, want.occurrences, o_occurrences,
                                 $sformatf("found %0b/%0b last %0b/%0b (expected/actual)",
                                           want.found, o_found, want.last, o_last));
                    end
                end
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [CODE_BITS-1:0] code);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid     = 1'b0;
            i_char_code = CODE_BITS'($urandom_range(255));
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_command   = cmd;
        i_char_code = code;
        forever begin
            @(posedge i_clk);
            if (o_ready) begin
                break;
            end
        end
        apply_word(cmd, code);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_entries.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CODE_BITS-1:0] random_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return '0;
        end else if (pick < 15) begin
            return CODE_BITS'($urandom_range(255, ALPHABET_SIZE));
        end else if (pick < 45) begin
            return CODE_BITS'($urandom_range(122, 97));
        end
        return CODE_BITS'($urandom_range(ALPHABET_SIZE - 1, 1));
    endfunction

    task automatic report_until_last(input int mid_count_pct);
        forever begin
            if ($urandom_range(99) < mid_count_pct) begin
                send_word(CMD_COUNT, random_text_byte());
            end
            send_word(CMD_REPORT, CODE_BITS'($urandom_range(255)));
            if (run_closed) begin
                break;
            end
        end
    endtask

    task automatic test_empty_report();
        send_word(CMD_REPORT, 8'hFF);
    endtask

    task automatic test_ignored_bytes();
        send_word(CMD_COUNT, 8'd0);
        send_word(CMD_COUNT, 8'd128);
        send_word(CMD_COUNT, 8'd255);
        send_word(CMD_COUNT, 8'd200);
        send_word(CMD_REPORT, 8'd0);
    endtask

    task automatic test_ascending_order();
        send_word(CMD_COUNT, 8'd127);
        send_word(CMD_COUNT, 8'd1);
        send_word(CMD_COUNT, 8'd85);
        send_word(CMD_COUNT, 8'd42);
        send_word(CMD_COUNT, 8'd1);
        report_until_last(0);
    endtask

    // A count for a code the scan has already passed is held but not reported,
    // and is gone once the run ends.
    task automatic test_count_behind_pointer();
        send_word(CMD_COUNT, 8'd65);
        send_word(CMD_COUNT, 8'd67);
        send_word(CMD_COUNT, 8'd69);
        send_word(CMD_REPORT, 8'd0);
        send_word(CMD_COUNT, 8'd65);
        send_word(CMD_COUNT, 8'd68);
        report_until_last(0);
        send_word(CMD_REPORT, 8'd0);
    endtask

    task automatic test_repeated_code();
        repeat (REPEAT_WORDS) send_word(CMD_COUNT, 8'd127);
        send_word(CMD_COUNT, 8'd1);
        report_until_last(0);
    endtask

    task automatic test_random_runs(input int n_words);
        int stop_at;
        int kind;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                repeat ($urandom_range(24, 1)) send_word(CMD_COUNT, random_text_byte());
                report_until_last(15);
            end else if (kind < 92) begin
                repeat ($urandom_range(8, 1)) begin
                    send_word(1'($urandom_range(1)), random_text_byte());
                end
            end else begin
                send_word(CMD_REPORT, CODE_BITS'($urandom_range(255)));
            end
        end
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // output register fills and the input stalls behind a report.
    task automatic test_backpressure();
        holdoff_requests++;
        repeat (3) begin
            repeat ($urandom_range(20, 5)) send_word(CMD_COUNT, random_text_byte());
            report_until_last(10);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_command        = CMD_COUNT;
        i_char_code      = '0;
        mismatch_count   = 0;
        words_sent       = 0;
        holdoff_requests = 0;
        run_closed       = 1'b0;
        send_idle_pct    = 8;
        recv_idle_pct    = 59;
        clear_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_report();
        test_ignored_bytes();
        test_ascending_order();
        test_count_behind_pointer();
        test_random_runs(320);
        wait_drained();

        send_idle_pct = 59;
        recv_idle_pct = 8;
        test_random_runs(330);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_repeated_code();
        test_backpressure();
        test_random_runs(290);
        wait_drained();

        mismatch_count += expected_entries.size();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* character_histogram.f */
src/chist_pkg.sv
src/chist_store.sv
src/chist_scan.sv
src/character_histogram.sv
src/chist_checker.sv
dv/tb_character_histogram.sv
